// ----- sv/tch_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tch_pkg: shared types and constants of the tilt-compensated heading unit
// Holds the angle format, the CORDIC arctangent table and the queue beat type.
// ----------------------------------------------------------------------------
package tch_pkg;

  // Angle accumulator resolution in bits of one turn, and CORDIC length
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;

  // Depth of the queue between the front and back ends
  localparam int Q_DEPTH = 2;

  // Width of the horizontal field terms and of the CORDIC datapath
  localparam int MXY_W = 48;
  localparam int XY_W  = 52;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURNS32 [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // Round a table entry to the accumulator resolution
  function automatic logic [ANGLE_BITS-1:0] atan_step(input logic [4:0] idx);
    logic [32:0] rnd;
    logic [32:0] t;
    rnd = (33'd1 << (32 - ANGLE_BITS)) >> 1;
    t   = ({1'b0, ATAN_TURNS32[idx]} + rnd) >> (32 - ANGLE_BITS);
    return t[ANGLE_BITS-1:0];
  endfunction

  // One queued sample set with its classification
  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] field_x;
    logic signed [15:0] field_y;
    logic signed [15:0] field_z;
    logic               tilt;
    logic               err;
  } tch_item_t;

endpackage
`default_nettype wire

// ----- sv/tch_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tch_front: input acceptance, classification and item queue
// Flags zero vectors, tags each beat with the tilt mode and queues it.
// ----------------------------------------------------------------------------
module tch_front import tch_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] accel_x_i,
  input  wire logic signed [15:0] accel_y_i,
  input  wire logic signed [15:0] accel_z_i,
  input  wire logic signed [15:0] field_x_i,
  input  wire logic signed [15:0] field_y_i,
  input  wire logic signed [15:0] field_z_i,
  output logic                    q_valid_o,
  output tch_item_t               q_item_o,
  input  wire logic               q_pop_i
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  logic             tilt_q;
  tch_item_t        mem_q [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;
  logic             mag_zero, acc_zero;
  tch_item_t        item;

  // Tilt mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tilt_q <= 1'b1;
    end else if (cfg_we_i) begin
      tilt_q <= cfg_wdata_i;
    end
  end

  // Classify the incoming beat
  always_comb begin
    mag_zero = (field_x_i == '0) && (field_y_i == '0) && (field_z_i == '0);
    acc_zero = (accel_x_i == '0) && (accel_y_i == '0) && (accel_z_i == '0);
    item.accel_x = accel_x_i;
    item.accel_y = accel_y_i;
    item.accel_z = accel_z_i;
    item.field_x = field_x_i;
    item.field_y = field_y_i;
    item.field_z = field_z_i;
    item.tilt    = tilt_q;
    item.err     = mag_zero || (tilt_q && acc_zero);
  end

  assign in_ready_o = (cnt_q != CNT_W'(Q_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Store the beat
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

endmodule
`default_nettype wire

// ----- sv/tch_isqrt.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tch_isqrt: iterative floor square root of a 32-bit value
// Produces one result bit per cycle; done pulses after sixteen steps.
// ----------------------------------------------------------------------------
module tch_isqrt import tch_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] arg_i,
  output logic             done_o,
  output logic [16:0]      root_o
);

  logic [31:0] n_q;
  logic [31:0] res_q;
  logic [30:0] bit_q;
  logic [3:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] trial;
  logic        take;

  assign trial  = {1'b0, res_q} + 33'(bit_q);
  assign take   = {1'b0, n_q} >= trial;
  assign done_o = done_q;
  assign root_o = res_q[16:0];

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 4'd15) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Subtract and shift one bit pair
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= arg_i;
      res_q <= '0;
      bit_q <= 31'h4000_0000;
    end else if (busy_q) begin
      if (take) begin
        n_q   <= n_q - trial[31:0];
        res_q <= (res_q >> 1) + 32'(bit_q);
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

endmodule
`default_nettype wire

// ----- sv/tch_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tch_div: restoring divider for a sixteen-bit quotient
// The dividend's upper bits must already be below the divisor.
// ----------------------------------------------------------------------------
module tch_div import tch_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [30:0] dividend_i,
  input  wire logic [16:0] divisor_i,
  output logic             done_o,
  output logic [15:0]      quot_o
);

  logic [16:0] rem_q, dvs_q;
  logic [15:0] low_q, quot_q;
  logic [3:0]  cnt_q;
  logic        busy_q, done_q;
  logic [17:0] trial;
  logic        ge;

  assign trial  = {rem_q, low_q[15]};
  assign ge     = trial >= {1'b0, dvs_q};
  assign done_o = done_q;
  assign quot_o = quot_q;

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 4'd15) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift in one dividend bit and subtract when it fits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {2'b00, dividend_i[30:16]};
      low_q  <= dividend_i[15:0];
      dvs_q  <= divisor_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? 17'(trial - {1'b0, dvs_q}) : trial[16:0];
      low_q  <= {low_q[14:0], 1'b0};
      quot_q <= {quot_q[14:0], ge};
    end
  end

endmodule
`default_nettype wire

// ----- sv/tch_cordic.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tch_cordic: vectoring CORDIC for the heading angle over one turn
// Handles the axis cases directly and folds the left half plane first.
// ----------------------------------------------------------------------------
module tch_cordic import tch_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [MXY_W-1:0] x_i,
  input  wire logic signed [MXY_W-1:0] y_i,
  output logic                         done_o,
  output logic [15:0]                  heading_o
);

  localparam int CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [ANGLE_BITS-1:0] HALF    = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  logic signed [XY_W-1:0]  x_q, y_q, xs, ys, x_ext, y_ext;
  logic [ANGLE_BITS-1:0]   z_q, t;
  logic [CNT_W-1:0]        cnt_q;
  logic                    busy_q, done_q;
  logic                    on_axis;
  logic [ANGLE_BITS+15:0]  z_wide;

  assign x_ext   = XY_W'(x_i);
  assign y_ext   = XY_W'(y_i);
  assign xs      = x_q >>> cnt_q;
  assign ys      = y_q >>> cnt_q;
  assign t       = atan_step(5'(cnt_q));
  assign on_axis = (x_i == '0) || (y_i == '0);
  assign z_wide  = {z_q, 16'b0};
  assign heading_o = z_wide[ANGLE_BITS+15 -: 16];
  assign done_o  = done_q;

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        if (on_axis) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Rotate toward the x axis and accumulate the angle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (x_i == '0) begin
        z_q <= (y_i > 0) ? QUARTER : HALF + QUARTER;
      end else if (y_i == '0) begin
        z_q <= (x_i > 0) ? '0 : HALF;
      end else if (x_i < 0) begin
        x_q <= -x_ext;
        y_q <= -y_ext;
        z_q <= HALF;
      end else begin
        x_q <= x_ext;
        y_q <= y_ext;
        z_q <= '0;
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + t;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - t;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/tch_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tch_back: heading sequencer with shared multiplier and iterative units
// Normalizes; in tilt mode derives pitch and roll and rotates the field; then finds the angle.
// ----------------------------------------------------------------------------
module tch_back import tch_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       q_valid_i,
  input  wire tch_item_t  q_item_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [15:0]     heading_o,
  output logic            error_o
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_SQ0   = 5'd1;
  localparam logic [4:0] ST_SQ1   = 5'd2;
  localparam logic [4:0] ST_SQ2   = 5'd3;
  localparam logic [4:0] ST_SQ3   = 5'd4;
  localparam logic [4:0] ST_NSQRT = 5'd5;
  localparam logic [4:0] ST_NDIV  = 5'd6;
  localparam logic [4:0] ST_PSQ0  = 5'd7;
  localparam logic [4:0] ST_PSQ1  = 5'd8;
  localparam logic [4:0] ST_PSQRT = 5'd9;
  localparam logic [4:0] ST_RDIV  = 5'd10;
  localparam logic [4:0] ST_RSQ0  = 5'd11;
  localparam logic [4:0] ST_RSQ1  = 5'd12;
  localparam logic [4:0] ST_RSQRT = 5'd13;
  localparam logic [4:0] ST_MX0   = 5'd14;
  localparam logic [4:0] ST_MX1   = 5'd15;
  localparam logic [4:0] ST_MX2   = 5'd16;
  localparam logic [4:0] ST_MX3   = 5'd17;
  localparam logic [4:0] ST_MX4   = 5'd18;
  localparam logic [4:0] ST_MX5   = 5'd19;
  localparam logic [4:0] ST_MX6   = 5'd20;
  localparam logic [4:0] ST_MX7   = 5'd21;
  localparam logic [4:0] ST_CHECK = 5'd22;
  localparam logic [4:0] ST_CORD  = 5'd23;
  localparam logic [4:0] ST_DONE  = 5'd24;

  localparam logic signed [16:0] SINR_POS = 17'sh08000;
  localparam logic signed [16:0] SINR_NEG = 17'sh18000;
  localparam logic [16:0]        COSR_ONE = 17'd32768;
  localparam logic [16:0]        COSP_MIN = 17'd32;
  localparam logic [31:0]        ONE_Q30  = 32'h4000_0000;

  logic [4:0]              state_q, state_d;
  logic                    tilt_q, which_q;
  logic signed [15:0]      fld_q [3];
  logic signed [15:0]      acr_q [3];
  logic signed [15:0]      mn_q [3];
  logic signed [15:0]      an_q [3];
  logic [16:0]             cosp_q, cosr_q;
  logic signed [16:0]      sinr_q;
  logic signed [MXY_W-1:0] acc_q, t_q, mx2_q, my2_q;
  logic signed [49:0]      prod_q;
  logic signed [31:0]      mul_a;
  logic signed [17:0]      mul_b;
  logic [15:0]             res_head_q;
  logic                    res_err_q;
  logic                    out_valid_q, out_err_q;
  logic [15:0]             out_head_q;

  logic signed [15:0] vec [3];
  logic [16:0]        vabs [3];
  logic signed [15:0] n_out [3];
  logic [16:0]        a1abs;
  logic [30:0]        a1_dvd;
  logic [31:0]        sat_thr;
  logic               sinr_sat;

  logic        sqrt_start, sqrt_done;
  logic [31:0] sqrt_arg;
  logic [16:0] sqrt_root;
  logic [2:0]  div_start, div_done;
  logic [30:0] div_dvd [3];
  logic [15:0] div_quot [3];
  logic        cord_start, cord_done;
  logic [15:0] cord_head;
  logic        load_out;

  // Clamp a quotient to Q1.15 and restore the sign
  function automatic logic signed [15:0] norm_out(input logic [15:0] q, input logic neg);
    logic [15:0] mag;
    mag = (q > 16'd32767) ? 16'd32767 : q;
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  // Select the vector under normalization
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vec[k]   = which_q ? acr_q[k] : fld_q[k];
      vabs[k]  = vec[k][15] ? 17'(-17'(vec[k])) : 17'(vec[k]);
      n_out[k] = norm_out(div_quot[k], vec[k][15]);
    end
    a1abs    = an_q[1][15] ? 17'(-17'(an_q[1])) : 17'(an_q[1]);
    a1_dvd   = 31'({a1abs, 15'b0});
    sat_thr  = 32'({sqrt_root, 15'b0}) + 32'(sqrt_root);
    sinr_sat = 32'(a1_dvd) >= sat_thr;
  end

  // Drive the iterative units
  always_comb begin
    sqrt_start = (state_q == ST_SQ3) || (state_q == ST_PSQ1) || (state_q == ST_RSQ1);
    if (state_q == ST_SQ3) begin
      sqrt_arg = 32'(50'(acc_q) + prod_q);
    end else begin
      sqrt_arg = ONE_Q30 - prod_q[31:0];
    end
    for (int k = 0; k < 3; k++) begin
      div_start[k] = (state_q == ST_NSQRT) && sqrt_done;
      div_dvd[k]   = 31'({vabs[k], 15'b0});
    end
    if (state_q == ST_PSQRT) begin
      div_start[0] = sqrt_done && (sqrt_root > COSP_MIN) && !sinr_sat;
      div_dvd[0]   = a1_dvd;
    end
    cord_start = (state_q == ST_CHECK) && !((mx2_q == '0) && (my2_q == '0));
  end

  // Pick multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQ0:  begin mul_a = 32'(vec[0]); mul_b = 18'(vec[0]); end
      ST_SQ1:  begin mul_a = 32'(vec[1]); mul_b = 18'(vec[1]); end
      ST_SQ2:  begin mul_a = 32'(vec[2]); mul_b = 18'(vec[2]); end
      ST_PSQ0: begin mul_a = 32'(an_q[0]); mul_b = 18'(an_q[0]); end
      ST_RSQ0: begin mul_a = 32'(sinr_q); mul_b = 18'(sinr_q); end
      ST_MX0:  begin mul_a = 32'(mn_q[0]); mul_b = $signed(18'(cosp_q)); end
      ST_MX1:  begin mul_a = 32'(mn_q[2]); mul_b = -18'(an_q[0]); end
      ST_MX2:  begin mul_a = 32'(mn_q[0]); mul_b = 18'(sinr_q); end
      ST_MX3:  begin mul_a = $signed(prod_q[31:0]); mul_b = -18'(an_q[0]); end
      ST_MX4:  begin mul_a = 32'(mn_q[1]); mul_b = $signed(18'(cosr_q)); end
      ST_MX5:  begin mul_a = 32'(mn_q[2]); mul_b = 18'(sinr_q); end
      ST_MX6:  begin mul_a = $signed(prod_q[31:0]); mul_b = $signed(18'(cosp_q)); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Sequence the steps
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (q_valid_i) state_d = q_item_i.err ? ST_DONE : ST_SQ0;
      ST_SQ0:   state_d = ST_SQ1;
      ST_SQ1:   state_d = ST_SQ2;
      ST_SQ2:   state_d = ST_SQ3;
      ST_SQ3:   state_d = ST_NSQRT;
      ST_NSQRT: if (sqrt_done) state_d = ST_NDIV;
      ST_NDIV: begin
        if (div_done[0]) begin
          if (which_q) state_d = ST_PSQ0;
          else if (tilt_q) state_d = ST_SQ0;
          else state_d = ST_CHECK;
        end
      end
      ST_PSQ0:  state_d = ST_PSQ1;
      ST_PSQ1:  state_d = ST_PSQRT;
      ST_PSQRT: begin
        if (sqrt_done) begin
          if (sqrt_root <= COSP_MIN) state_d = ST_MX0;
          else if (sinr_sat) state_d = ST_RSQ0;
          else state_d = ST_RDIV;
        end
      end
      ST_RDIV:  if (div_done[0]) state_d = ST_RSQ0;
      ST_RSQ0:  state_d = ST_RSQ1;
      ST_RSQ1:  state_d = ST_RSQRT;
      ST_RSQRT: if (sqrt_done) state_d = ST_MX0;
      ST_MX0:   state_d = ST_MX1;
      ST_MX1:   state_d = ST_MX2;
      ST_MX2:   state_d = ST_MX3;
      ST_MX3:   state_d = ST_MX4;
      ST_MX4:   state_d = ST_MX5;
      ST_MX5:   state_d = ST_MX6;
      ST_MX6:   state_d = ST_MX7;
      ST_MX7:   state_d = ST_CHECK;
      ST_CHECK: state_d = cord_start ? ST_CORD : ST_DONE;
      ST_CORD:  if (cord_done) state_d = ST_DONE;
      ST_DONE:  if (load_out) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign q_pop_o  = (state_q == ST_IDLE) && q_valid_i;
  assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // Control state and output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (load_out) begin
      out_head_q <= res_head_q;
      out_err_q  <= res_err_q;
    end
    case (state_q)
      ST_IDLE: begin
        tilt_q     <= q_item_i.tilt;
        which_q    <= 1'b0;
        fld_q[0]   <= q_item_i.field_x;
        fld_q[1]   <= q_item_i.field_y;
        fld_q[2]   <= q_item_i.field_z;
        acr_q[0]   <= q_item_i.accel_x;
        acr_q[1]   <= q_item_i.accel_y;
        acr_q[2]   <= q_item_i.accel_z;
        res_head_q <= '0;
        res_err_q  <= 1'b1;
      end
      ST_SQ1: acc_q <= MXY_W'(prod_q);
      ST_SQ2: acc_q <= acc_q + MXY_W'(prod_q);
      ST_NDIV: begin
        if (div_done[0]) begin
          if (which_q) begin
            for (int k = 0; k < 3; k++) an_q[k] <= n_out[k];
          end else begin
            for (int k = 0; k < 3; k++) mn_q[k] <= n_out[k];
            mx2_q   <= MXY_W'(n_out[0]) <<< 30;
            my2_q   <= MXY_W'(n_out[1]) <<< 30;
            which_q <= 1'b1;
          end
        end
      end
      ST_PSQRT: begin
        if (sqrt_done) begin
          cosp_q <= sqrt_root;
          if (sqrt_root <= COSP_MIN) begin
            sinr_q <= '0;
            cosr_q <= COSR_ONE;
          end else if (sinr_sat) begin
            sinr_q <= an_q[1][15] ? SINR_NEG : SINR_POS;
          end
        end
      end
      ST_RDIV: begin
        if (div_done[0]) begin
          sinr_q <= an_q[1][15] ? -$signed(17'(div_quot[0])) : $signed(17'(div_quot[0]));
        end
      end
      ST_RSQRT: if (sqrt_done) cosr_q <= sqrt_root;
      ST_MX1:   t_q <= MXY_W'(prod_q);
      ST_MX2:   mx2_q <= MXY_W'((50'(t_q) + prod_q) <<< 15);
      ST_MX4:   acc_q <= MXY_W'(prod_q);
      ST_MX5:   acc_q <= acc_q + MXY_W'(prod_q <<< 15);
      ST_MX7:   my2_q <= acc_q - MXY_W'(prod_q);
      ST_CORD: begin
        if (cord_done) begin
          res_head_q <= cord_head;
          res_err_q  <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign heading_o   = out_head_q;
  assign error_o     = out_err_q;

  tch_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .arg_i   (sqrt_arg),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  for (genvar g = 0; g < 3; g++) begin : g_div
    tch_div u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (div_start[g]),
      .dividend_i (div_dvd[g]),
      .divisor_i  (sqrt_root),
      .done_o     (div_done[g]),
      .quot_o     (div_quot[g])
    );
  end

  tch_cordic u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cord_start),
    .x_i       (mx2_q),
    .y_i       (my2_q),
    .done_o    (cord_done),
    .heading_o (cord_head)
  );

  // An error beat always carries a zero heading
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> heading_o == '0)
    else $error("error beat with nonzero heading");

  // Root results arrive only while a square-root step waits
  a_sqrt_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> (state_q == ST_NSQRT) || (state_q == ST_PSQRT) || (state_q == ST_RSQRT))
    else $error("square root finished outside a wait state");

  // Quotients arrive only while a divide step waits
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done[0] |-> (state_q == ST_NDIV) || (state_q == ST_RDIV))
    else $error("divide finished outside a wait state");

  // The angle unit finishes only during the angle step
  a_cord_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cord_done |-> state_q == ST_CORD)
    else $error("angle finished outside its step");

endmodule
`default_nettype wire

// ----- sv/tilt_compensated_heading_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tilt_compensated_heading_unit: electronic compass heading with tilt correction
// Front end queues classified samples; back end computes the heading.
// ----------------------------------------------------------------------------
// Each accepted beat yields one result beat, in order. An item uses the shared
// 16-step square-root unit (up to four passes with tilt compensation on, one
// with it off), the 16-step dividers (up to three passes) and the 16-step
// CORDIC; zero-vector items skip these and go straight to the output. The
// two-entry input queue accepts new beats while the back end works, and the
// output register holds a finished beat until it is taken.
module tilt_compensated_heading_unit import tch_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] accel_x_i,
  input  wire logic signed [15:0] accel_y_i,
  input  wire logic signed [15:0] accel_z_i,
  input  wire logic signed [15:0] field_x_i,
  input  wire logic signed [15:0] field_y_i,
  input  wire logic signed [15:0] field_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [15:0]             heading_o,
  output logic                    error_o
);

  logic      q_valid, q_pop;
  tch_item_t q_item;

  tch_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .accel_x_i   (accel_x_i),
    .accel_y_i   (accel_y_i),
    .accel_z_i   (accel_z_i),
    .field_x_i   (field_x_i),
    .field_y_i   (field_y_i),
    .field_z_i   (field_z_i),
    .q_valid_o   (q_valid),
    .q_item_o    (q_item),
    .q_pop_i     (q_pop)
  );

  tch_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .heading_o   (heading_o),
    .error_o     (error_o)
  );

endmodule
`default_nettype wire
